// ----- hw/rtl/mirror_flip_with_channel_reflection_macros.svh -----
// ----------------------------------------------------------------------------
// mirror flip assertion macros
// shared property forms for the mirror flip block
// ----------------------------------------------------------------------------
`ifndef MIRROR_FLIP_WITH_CHANNEL_REFLECTION_MACROS_SVH
`define MIRROR_FLIP_WITH_CHANNEL_REFLECTION_MACROS_SVH

// condition holds at every edge out of reset
`define MFCR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds at the next edge after the antecedent
`define MFCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mfcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfcr_pkg
// types and constants shared by the mirror flip block
// ----------------------------------------------------------------------------
`default_nettype none

package mfcr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LANE_MAX    = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int ROW_WIDTH_W = 11;
   localparam int ROW_WIDTH_RESET = 1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLIP_ENABLE  = 3'd0,
      CSR_ROW_WIDTH    = 3'd1,
      CSR_CHANNEL_MASK = 3'd2,
      CSR_COEF_ZERO    = 3'd3,
      CSR_COEF_ONE     = 3'd4,
      CSR_COEF_TWO     = 3'd5,
      CSR_COEF_THREE   = 3'd6
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [LANE_MAX-1:0][SAMPLE_W-1:0] pixel_type;
   typedef logic [LANE_MAX-1:0][CSR_DATA_W-1:0] coef_set_type;

   typedef struct packed {
      logic       func;
      sample_type in_ch3;
      sample_type in_ch2;
      sample_type in_ch1;
      sample_type in_ch0;
   } req_word_type;

   typedef struct packed {
      sample_type out_ch3;
      sample_type out_ch2;
      sample_type out_ch1;
      sample_type out_ch0;
      logic       row_end;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic row_end;
   } stage_ctrl_type;

   typedef struct packed {
      logic                flip;
      logic [LANE_MAX-1:0] mask;
      coef_set_type        coef;
   } refl_cfg_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mfcr_chan_if.sv -----
// ----------------------------------------------------------------------------
// mfcr channel interfaces
// valid/ready channels for pixel requests and processed pixel responses
// ----------------------------------------------------------------------------
`default_nettype none

interface mfcr_req_if;
   import mfcr_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mfcr_rsp_if;
   import mfcr_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mfcr_reflect.sv -----
// ----------------------------------------------------------------------------
// mfcr_reflect
// householder reflection pipeline for masked lanes with flip set: products,
// rounded dot product, scaled update, rounding and saturation, output register
// ----------------------------------------------------------------------------
`default_nettype none

module mfcr_reflect #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfcr_pkg::stage_ctrl_type in_ctrl,
   input  mfcr_pkg::pixel_type      in_px,
   input  mfcr_pkg::refl_cfg_type   cfg,
   output logic                    advance,
   output mfcr_pkg::rsp_word_type   out_word,
   output logic                    out_valid,
   input  logic                    out_ready
);
   import mfcr_pkg::*;

   localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

   stage_ctrl_type     c2_ff, c3_ff, c4_ff;
   pixel_type          x2_ff, x3_ff, x4_ff;
   logic signed [31:0] prod_ff [LANE_MAX];
   logic signed [31:0] prod_in [LANE_MAX];
   logic signed [25:0] z14_ff, z14_in;
   logic signed [41:0] p_ff [LANE_MAX];
   logic signed [41:0] p_in [LANE_MAX];
   logic signed [33:0] z_sum;
   logic signed [43:0] v_full [LANE_MAX];
   logic signed [23:0] r_round [LANE_MAX];
   logic signed [32:0] r_ext [LANE_MAX];
   sample_type         y_lane [LANE_MAX];
   rsp_word_type       out_word_ff, out_word_in;
   logic               out_valid_ff;

   assign advance   = !out_valid_ff || out_ready;
   assign out_word  = out_word_ff;
   assign out_valid = out_valid_ff;

   always_comb begin
      for (int k = 0; k < LANE_MAX; k++) begin
         if (cfg.mask[k]) begin
            prod_in[k] = $signed(cfg.coef[k]) * $signed(in_px[k]);
         end else begin
            prod_in[k] = '0;
         end
      end
   end

   // dot product rounded to 6 fraction bits, half up
   always_comb begin
      z_sum = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      z14_in = 26'((z_sum + 34'sd128) >>> 8);
   end

   always_comb begin
      for (int k = 0; k < LANE_MAX; k++) begin
         p_in[k] = 42'(z14_ff) * 42'($signed(cfg.coef[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < LANE_MAX; k++) begin
         v_full[k]  = (44'($signed(x4_ff[k])) <<< 20) - (44'(p_ff[k]) <<< 1);
         r_round[k] = 24'((v_full[k] + 44'sd524288) >>> 20);
         r_ext[k]   = 33'(r_round[k]);
         if (cfg.flip && cfg.mask[k]) begin
            if (r_ext[k] > SAT_HI) begin
               y_lane[k] = SAT_HI[SAMPLE_W-1:0];
            end else if (r_ext[k] < SAT_LO) begin
               y_lane[k] = SAT_LO[SAMPLE_W-1:0];
            end else begin
               y_lane[k] = r_ext[k][SAMPLE_W-1:0];
            end
         end else begin
            y_lane[k] = $signed(x4_ff[k]);
         end
      end
      out_word_in.out_ch0 = y_lane[0];
      out_word_in.out_ch1 = y_lane[1];
      out_word_in.out_ch2 = y_lane[2];
      out_word_in.out_ch3 = y_lane[3];
      out_word_in.row_end = c4_ff.row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff        <= '0;
         c3_ff        <= '0;
         c4_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         c2_ff        <= in_ctrl;
         c3_ff        <= c2_ff;
         c4_ff        <= c3_ff;
         out_valid_ff <= c4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff       <= in_px;
         x3_ff       <= x2_ff;
         x4_ff       <= x3_ff;
         z14_ff      <= z14_in;
         out_word_ff <= out_word_in;
         for (int k = 0; k < LANE_MAX; k++) begin
            prod_ff[k] <= prod_in[k];
            p_ff[k]    <= p_in[k];
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mirror_flip_with_channel_reflection.sv -----
// ----------------------------------------------------------------------------
// mirror_flip_with_channel_reflection
// ping-pong line store; with flip set, mirrored readout and householder reflection
// a word read out on accept passes, in order, the registers of the store read,
//   products, rounded dot product, scaled update and output register
// throughput: one word per cycle; the store has one read and one write port,
//   a held response stalls the whole pipe and the input
// reset: synchronous, resets counters, configuration registers and pipeline valids only
// ----------------------------------------------------------------------------
`default_nettype none

module mirror_flip_with_channel_reflection #(
   parameter int MAX_WIDTH   = 1024,
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mfcr_req_if.sink                             req_chan,
   mfcr_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [mfcr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mfcr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mfcr_pkg::*;
   `include "mirror_flip_with_channel_reflection_macros.svh"

   localparam int LANES  = (CHANNELS < LANE_MAX) ? CHANNELS : LANE_MAX;
   localparam int SB     = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SH     = SAMPLE_W - SB;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;
   localparam int ADDR_W = COL_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int MEM_W  = LANES * SAMPLE_W;
   localparam logic [EW-1:0] MAX_EXT = EW'(MAX_WIDTH);
   localparam logic [LANE_MAX-1:0] LANE_BITS = LANE_MAX'((1 << LANES) - 1);

   // configuration
   logic                   flip_ff;
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [LANE_MAX-1:0]    mask_ff;
   coef_set_type           coef_ff;

   // row bookkeeping
   logic [CNT_W-1:0] write_col_ff, write_col_in;
   logic             write_half_ff, write_half_in;
   logic [CNT_W-1:0] read_col_ff, read_col_in;
   logic [CNT_W-1:0] pending_ff, pending_in;

   logic [MEM_W-1:0]  line_mem [DEPTH];
   logic [MEM_W-1:0]  rd_ff;
   logic [MEM_W-1:0]  wr_word;
   stage_ctrl_type    s1_ff;

   logic             adv;
   logic             accept;
   logic             has_pend;
   logic             row_done;
   logic [EW-1:0]    rw_ext;
   logic [EW-1:0]    eff_width;
   logic [CNT_W-1:0] wcol_inc;
   logic [CNT_W-1:0] rd_col;
   logic [ADDR_W-1:0] raddr, waddr;
   pixel_type        in_px;
   pixel_type        rd_px;
   refl_cfg_type     cfg;

   assign in_px = {req_chan.data.in_ch3, req_chan.data.in_ch2,
                   req_chan.data.in_ch1, req_chan.data.in_ch0};

   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;
   assign has_pend       = (pending_ff != '0);

   always_comb begin
      rw_ext = EW'(row_width_ff);
      if (row_width_ff == '0) begin
         eff_width = EW'(1);
      end else if (rw_ext > MAX_EXT) begin
         eff_width = MAX_EXT;
      end else begin
         eff_width = rw_ext;
      end
   end

   // mirrored readout walks the pending count down
   assign rd_col   = flip_ff ? (pending_ff - CNT_W'(1)) : read_col_ff;
   assign raddr    = {~write_half_ff, rd_col[COL_W-1:0]};
   assign waddr    = {write_half_ff, write_col_ff[COL_W-1:0]};
   assign wcol_inc = write_col_ff + CNT_W'(1);
   assign row_done = accept && !req_chan.data.func && (EW'(wcol_inc) >= eff_width);

   always_comb begin
      pending_in    = pending_ff;
      read_col_in   = read_col_ff;
      write_col_in  = write_col_ff;
      write_half_in = write_half_ff;
      if (accept) begin
         if (has_pend) begin
            pending_in  = pending_ff - CNT_W'(1);
            read_col_in = read_col_ff + CNT_W'(1);
         end
         if (!req_chan.data.func) begin
            if (row_done) begin
               // a row still pending is dropped here
               pending_in    = wcol_inc;
               read_col_in   = '0;
               write_half_in = ~write_half_ff;
               write_col_in  = '0;
            end else begin
               write_col_in = wcol_inc;
            end
         end
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [SAMPLE_W-1:0] shifted;
      assign shifted = in_px[k] << SH;
      assign wr_word[k*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($signed(shifted) >>> SH);
      assign rd_px[k] = rd_ff[k*SAMPLE_W +: SAMPLE_W];
   end
   for (genvar k = LANES; k < LANE_MAX; k++) begin : g_idle_lane
      assign rd_px[k] = '0;
   end

   always_ff @(posedge clock) begin
      if (accept && !req_chan.data.func) begin
         line_mem[waddr] <= wr_word;
      end
      if (adv) begin
         rd_ff <= line_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff       <= 1'b0;
         row_width_ff  <= ROW_WIDTH_W'(ROW_WIDTH_RESET);
         mask_ff       <= '0;
         coef_ff       <= '0;
         write_col_ff  <= '0;
         write_half_ff <= 1'b0;
         read_col_ff   <= '0;
         pending_ff    <= '0;
         s1_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FLIP_ENABLE:  flip_ff      <= csr_wdata[0];
               CSR_ROW_WIDTH:    row_width_ff <= csr_wdata[ROW_WIDTH_W-1:0];
               CSR_CHANNEL_MASK: mask_ff      <= csr_wdata[LANE_MAX-1:0];
               CSR_COEF_ZERO:    coef_ff[0]   <= csr_wdata;
               CSR_COEF_ONE:     coef_ff[1]   <= csr_wdata;
               CSR_COEF_TWO:     coef_ff[2]   <= csr_wdata;
               CSR_COEF_THREE:   coef_ff[3]   <= csr_wdata;
               default: ;
            endcase
         end
         write_col_ff  <= write_col_in;
         write_half_ff <= write_half_in;
         read_col_ff   <= read_col_in;
         pending_ff    <= pending_in;
         if (adv) begin
            s1_ff.valid   <= accept && has_pend;
            s1_ff.row_end <= (pending_ff == CNT_W'(1));
         end
      end
   end

   assign cfg.flip = flip_ff;
   assign cfg.mask = mask_ff & LANE_BITS;
   assign cfg.coef = coef_ff;

   mfcr_reflect #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_reflect (
      .clock     (clock),
      .reset     (reset),
      .in_ctrl   (s1_ff),
      .in_px     (rd_px),
      .cfg       (cfg),
      .advance   (adv),
      .out_word  (rsp_chan.data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready)
   );

   `MFCR_ASSERT_ALWAYS(a_row_bound, clock, reset, ({1'b0, read_col_ff} + {1'b0, pending_ff}) <= (CNT_W + 1)'(MAX_WIDTH), "read position and pending count exceed the row store")
   `MFCR_ASSERT_NEXT(a_readout_issued, clock, reset, accept && has_pend, s1_ff.valid, "pending pixel read without a result in flight")
   `MFCR_ASSERT_NEXT(a_half_swap, clock, reset, row_done, (write_half_ff != $past(write_half_ff)) && (write_col_ff == '0), "completed row did not swap store halves")
   `MFCR_ASSERT_NEXT(a_read_held, clock, reset, !adv, $stable(s1_ff) && (!s1_ff.valid || $stable(rd_ff)), "store read data moved during a stall")

endmodule

`default_nettype wire
